>>> rtl/core/isu_pkg.sv
package isu_pkg;

  localparam int COUNT_W = 9;

  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_PRESENT = 2'd1;
  localparam logic [1:0] STATUS_ABSENT  = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               present;
    logic [COUNT_W-1:0] count_greater;
    logic [COUNT_W-1:0] count_less;
    logic [COUNT_W-1:0] set_size;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } entry_t;

endpackage

>>> rtl/core/isu_cell.sv
module isu_cell (
  input  logic            clk,
  input  logic            rst,
  input  isu_pkg::entry_t d,
  output isu_pkg::entry_t q
);
  import isu_pkg::*;

  logic               valid;
  logic signed [31:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= d.value;
  end

  assign q = '{valid: valid, value: value};

endmodule

>>> rtl/core/integer_set_store_unit.sv
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  req (kind, value)
// result    out        rsp_valid/rsp_stall  rsp (status, present, counts, set size)
//
// Entries circulate through a ring of CAPACITY cells, one position per cycle.
// A request scans the whole ring as it passes the ring tail, then posts the
// result from FINISH; an insert of an absent value into a set that is not full
// first waits in PLACE for a free cell to reach the tail. Requests are taken one
// at a time. Reset clears all cell valid bits and the size. The result register
// frees the request side while a result is stalled.
module integer_set_store_unit #(
  parameter int CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  isu_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output isu_pkg::rsp_t rsp
);
  import isu_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_N = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  typedef enum logic [1:0] {IDLE, SCAN, PLACE, FINISH} state_t;

  state_t             state;
  logic [1:0]         kind;
  logic signed [31:0] key;
  logic [CW-1:0]      greater;
  logic [CW-1:0]      less;
  logic [CW-1:0]      n;
  logic               found;
  logic [IW-1:0]      idx;

  entry_t ring [CAPACITY];
  entry_t feed;
  entry_t tail;
  logic   is_gt;
  logic   is_lt;
  logic   is_eq;

  assign tail  = ring[CAPACITY-1];
  assign is_gt = tail.valid && (tail.value > key);
  assign is_lt = tail.valid && (tail.value < key);
  assign is_eq = tail.valid && (tail.value == key);

  always_comb begin
    feed = tail;
    if (state == SCAN && kind == KIND_DELETE && is_eq) begin
      feed.valid = 1'b0;
    end else if (state == PLACE && !tail.valid) begin
      feed = '{valid: 1'b1, value: key};
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      isu_cell u_cell (.clk(clk), .rst(rst), .d(feed), .q(ring[0]));
    end else begin : g_body
      isu_cell u_cell (.clk(clk), .rst(rst), .d(ring[i-1]), .q(ring[i]));
    end
  end

  assign req_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      n         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            kind    <= req.kind;
            key     <= req.value;
            greater <= '0;
            less    <= '0;
            found   <= 1'b0;
            idx     <= '0;
            state   <= SCAN;
          end
        end
        SCAN: begin
          greater <= greater + CW'(is_gt);
          less    <= less + CW'(is_lt);
          found   <= found | is_eq;
          idx     <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            if (kind == KIND_INSERT && !(found || is_eq) && n != CAP_N) begin
              state <= PLACE;
            end else begin
              state <= FINISH;
            end
          end
        end
        PLACE: begin
          if (!tail.valid) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.present       <= found;
            rsp.count_greater <= COUNT_W'(greater);
            rsp.count_less    <= COUNT_W'(less);
            case (kind)
              KIND_INSERT: begin
                if (found) begin
                  rsp.status   <= STATUS_PRESENT;
                  rsp.set_size <= COUNT_W'(n);
                end else if (n == CAP_N) begin
                  rsp.status   <= STATUS_FULL;
                  rsp.set_size <= COUNT_W'(n);
                end else begin
                  n            <= n + 1'b1;
                  rsp.status   <= STATUS_DONE;
                  rsp.set_size <= COUNT_W'(n + 1'b1);
                end
              end
              KIND_DELETE: begin
                if (!found) begin
                  rsp.status   <= STATUS_ABSENT;
                  rsp.set_size <= COUNT_W'(n);
                end else begin
                  n            <= n - 1'b1;
                  rsp.status   <= STATUS_DONE;
                  rsp.set_size <= COUNT_W'(n - 1'b1);
                end
              end
              default: begin
                rsp.status   <= STATUS_DONE;
                rsp.set_size <= COUNT_W'(n);
              end
            endcase
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import isu_pkg::*;

  localparam int CAPACITY = 256;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int HOLD_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 5000000;
  localparam int MAX_PRINTED = 40;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic signed [31:0] model_set[$];
  rsp_t pending_rsp_q[$];
  int error_count = 0;
  longint cycle_count = 0;
  int burst_left = 0;
  bit sender_gaps_on = 1'b1;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  integer_set_store_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic rsp_t apply_set_op(input logic [1:0] op, input logic signed [31:0] val);
    rsp_t r;
    int greater;
    int less;
    int hit_at;
    bit hit;
    greater = 0;
    less = 0;
    hit_at = 0;
    hit = 1'b0;
    foreach (model_set[i]) begin
      if (model_set[i] > val) greater++;
      else if (model_set[i] < val) less++;
      else begin
        hit = 1'b1;
        hit_at = i;
      end
    end
    r.status = STATUS_DONE;
    if (op == KIND_INSERT) begin
      if (hit) r.status = STATUS_PRESENT;
      else if (model_set.size() >= CAPACITY) r.status = STATUS_FULL;
      else model_set.push_back(val);
    end else if (op == KIND_DELETE) begin
      if (!hit) r.status = STATUS_ABSENT;
      else model_set.delete(hit_at);
    end
    r.present = hit;
    r.count_greater = COUNT_W'(greater);
    r.count_less = COUNT_W'(less);
    r.set_size = COUNT_W'(model_set.size());
    return r;
  endfunction

  function automatic logic signed [31:0] pick_stored();
    if (model_set.size() == 0) return $urandom;
    return model_set[$urandom_range(0, model_set.size() - 1)];
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic send_req(input logic [1:0] op, input logic signed [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (sender_gaps_on) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 700) : $urandom_range(0, 20);
      end
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= '{kind: op, value: val};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp_q.push_back(apply_set_op(op, val));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: %p", rsp));
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("status", 32'(rsp.status), 32'(want.status));
        check_field("present", 32'(rsp.present), 32'(want.present));
        check_field("count_greater", 32'(rsp.count_greater), 32'(want.count_greater));
        check_field("count_less", 32'(rsp.count_less), 32'(want.count_less));
        check_field("set_size", 32'(rsp.set_size), 32'(want.set_size));
      end
    end
  end

  // The receiver switches between stall patterns and honors long hold requests.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 2);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  task automatic test_directed();
    send_req(KIND_QUERY, 32'sd0);
    send_req(KIND_DELETE, 32'sd7);
    send_req(KIND_INSERT, VAL_MIN);
    send_req(KIND_INSERT, VAL_MAX);
    send_req(KIND_INSERT, 32'sd0);
    send_req(KIND_INSERT, -32'sd1);
    send_req(KIND_INSERT, 32'sd1);
    send_req(KIND_INSERT, VAL_MAX);
    send_req(KIND_QUERY, VAL_MIN);
    send_req(KIND_QUERY, VAL_MAX);
    send_req(KIND_QUERY, 32'sd0);
    send_req(KIND_QUERY, 32'sd2);
    send_req(KIND_UNUSED, 32'sd1);
    send_req(KIND_UNUSED, VAL_MIN);
    send_req(KIND_DELETE, 32'sd0);
    send_req(KIND_DELETE, 32'sd0);
    send_req(KIND_QUERY, 32'sd0);
    send_req(KIND_DELETE, VAL_MIN);
    send_req(KIND_DELETE, VAL_MAX);
    send_req(KIND_INSERT, 32'sh5555_5555);
    send_req(KIND_INSERT, 32'shAAAA_AAAA);
    send_req(KIND_QUERY, -32'sd1);
    wait_drained();
  endtask

  task automatic test_small_pool(input int n, input bit gaps);
    logic signed [31:0] pool[16];
    logic [1:0] op;
    int r;
    sender_gaps_on = gaps;
    pool[0] = VAL_MIN;
    pool[1] = VAL_MAX;
    pool[2] = 32'sd0;
    pool[3] = -32'sd1;
    for (int i = 4; i < 16; i++) pool[i] = $urandom;
    repeat (n) begin
      r = $urandom_range(0, 9);
      op = (r < 4) ? KIND_INSERT : (r < 7) ? KIND_DELETE : (r < 9) ? KIND_QUERY : KIND_UNUSED;
      send_req(op, pool[4'($urandom_range(0, 15))]);
    end
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_req++;
    repeat (8) send_req(2'($urandom_range(0, 3)), $urandom);
    wait_drained();
  endtask

  task automatic test_fill_to_capacity();
    while (model_set.size() < CAPACITY) begin
      if ($urandom_range(0, 9) == 0) send_req(KIND_INSERT, pick_stored());
      else if ($urandom_range(0, 9) == 0) send_req(KIND_QUERY, $urandom);
      else send_req(KIND_INSERT, $urandom);
    end
    send_req(KIND_QUERY, VAL_MIN);
    send_req(KIND_QUERY, VAL_MAX);
    send_req(KIND_INSERT, VAL_MIN);
    repeat (40) begin
      case ($urandom_range(0, 4))
        0: send_req(KIND_INSERT, $urandom);
        1: send_req(KIND_INSERT, pick_stored());
        2: send_req(KIND_QUERY, pick_stored());
        3: send_req(KIND_UNUSED, $urandom);
        default: begin
          send_req(KIND_DELETE, pick_stored());
          send_req(KIND_INSERT, $urandom);
        end
      endcase
    end
  endtask

  task automatic test_drain();
    int r;
    while (model_set.size() > 4) begin
      r = $urandom_range(0, 19);
      if (r < 16) send_req(KIND_DELETE, pick_stored());
      else if (r == 16) send_req(KIND_DELETE, $urandom);
      else if (r == 17) send_req(KIND_QUERY, pick_stored());
      else send_req(KIND_INSERT, $urandom);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_pool(70, 1'b1);
    test_small_pool(70, 1'b0);
    test_backpressure();
    test_fill_to_capacity();
    test_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
